// ----- rtl/brc_pkg.sv -----
// Shared types and constants for the buffer recycle cache.
package brc_pkg;

  // Default number of cache entries (cells in the chain)
  localparam int unsigned ENTRIES_DEF = 8;

  // Field widths
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned HDL_W   = 64;
  localparam int unsigned STAMP_W = 32;

  // Starting value of the oldest-stamp search
  localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

  // Request codes
  localparam logic MODE_TAKE    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Control group that travels down the cell chain with a request
  typedef struct packed {
    logic valid;   // a request occupies this stage
    logic mode;    // MODE_TAKE or MODE_RELEASE
    logic done;    // already served (take hit, insert, or null release)
    logic hit;     // take found a matching entry
    logic picked;  // a victim candidate has been recorded
  } brc_ctl_t;

endpackage

// ----- rtl/brc_in_if.sv -----
// Request channel: valid/ready handshake with take/release payload.
interface brc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [brc_pkg::SIZE_W-1:0]  size_bytes;
  logic [brc_pkg::HDL_W-1:0]   handle;

  modport source (output valid, output mode, output size_bytes, output handle,
                  input ready);
  modport sink   (input valid, input mode, input size_bytes, input handle,
                  output ready);
endinterface

// ----- rtl/brc_out_if.sv -----
// Result channel: valid/ready handshake with hit and eviction payload.
interface brc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [brc_pkg::HDL_W-1:0]   out_handle;
  logic                        evict_valid;
  logic [brc_pkg::HDL_W-1:0]   evict_handle;

  modport source (output valid, output hit, output out_handle, output evict_valid,
                  output evict_handle, input ready);
  modport sink   (input valid, input hit, input out_handle, input evict_valid,
                  input evict_handle, output ready);
endinterface

// ----- rtl/brc_cell.sv -----
// One cache entry. A request is registered on its way through: a take may claim
// the entry, a release may fill it if empty, otherwise the entry competes
// as the oldest victim. The chain end can overwrite the entry by index.
module brc_cell #(
  parameter int unsigned      IDX_W = 3,
  parameter logic [IDX_W-1:0] IDX   = '0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request from the previous cell
  input  brc_pkg::brc_ctl_t             ctl_in,
  input  logic [brc_pkg::SIZE_W-1:0]    size_in,
  input  logic [brc_pkg::HDL_W-1:0]     hdl_in,
  input  logic [brc_pkg::STAMP_W-1:0]   stamp_in,
  input  logic [brc_pkg::HDL_W-1:0]     res_in,
  input  logic [brc_pkg::STAMP_W-1:0]   best_stamp_in,
  input  logic [IDX_W-1:0]              best_idx_in,
  // victim overwrite from the chain end
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [brc_pkg::SIZE_W-1:0]    wr_size,
  input  logic [brc_pkg::HDL_W-1:0]     wr_hdl,
  input  logic [brc_pkg::STAMP_W-1:0]   wr_stamp,
  // request to the next cell
  output brc_pkg::brc_ctl_t             ctl_out,
  output logic [brc_pkg::SIZE_W-1:0]    size_out,
  output logic [brc_pkg::HDL_W-1:0]     hdl_out,
  output logic [brc_pkg::STAMP_W-1:0]   stamp_out,
  output logic [brc_pkg::HDL_W-1:0]     res_out,
  output logic [brc_pkg::STAMP_W-1:0]   best_stamp_out,
  output logic [IDX_W-1:0]              best_idx_out
);

  // Entry storage
  logic                          occ_r, occ_nxt;
  logic [brc_pkg::SIZE_W-1:0]    size_r, size_nxt;
  logic [brc_pkg::HDL_W-1:0]     hdl_r, hdl_nxt;
  logic [brc_pkg::STAMP_W-1:0]   stamp_r, stamp_nxt;

  // Outgoing request stage
  brc_pkg::brc_ctl_t             ctl_r, ctl_nxt;
  logic [brc_pkg::SIZE_W-1:0]    osize_r;
  logic [brc_pkg::HDL_W-1:0]     ohdl_r;
  logic [brc_pkg::STAMP_W-1:0]   ostamp_r;
  logic [brc_pkg::HDL_W-1:0]     res_r, res_nxt;
  logic [brc_pkg::STAMP_W-1:0]   bstamp_r, bstamp_nxt;
  logic [IDX_W-1:0]              bidx_r, bidx_nxt;

  logic live, take_hit, ins, older, wr_here;

  // Per-entry decisions
  always_comb begin
    live     = ctl_in.valid && !ctl_in.done;
    take_hit = live && (ctl_in.mode == brc_pkg::MODE_TAKE) && occ_r && (size_r == size_in);
    ins      = live && (ctl_in.mode == brc_pkg::MODE_RELEASE) && !occ_r;
    // strict compare keeps the lowest index on equal stamps
    older    = live && (ctl_in.mode == brc_pkg::MODE_RELEASE) && occ_r &&
               (!ctl_in.picked || (stamp_r < best_stamp_in));
    wr_here  = wr_en && (wr_idx == IDX);
  end

  // Entry update
  always_comb begin
    occ_nxt   = occ_r;
    size_nxt  = size_r;
    hdl_nxt   = hdl_r;
    stamp_nxt = stamp_r;
    if (take_hit) begin
      occ_nxt = 1'b0;
    end else if (ins) begin
      occ_nxt   = 1'b1;
      size_nxt  = size_in;
      hdl_nxt   = hdl_in;
      stamp_nxt = stamp_in;
    end else if (wr_here) begin
      size_nxt  = wr_size;
      hdl_nxt   = wr_hdl;
      stamp_nxt = wr_stamp;
    end
  end

  // Request hand-on
  always_comb begin
    ctl_nxt        = ctl_in;
    ctl_nxt.done   = ctl_in.done || take_hit || ins;
    ctl_nxt.hit    = ctl_in.hit || take_hit;
    ctl_nxt.picked = ctl_in.picked || older;
    res_nxt        = (take_hit || older) ? hdl_r : res_in;
    bstamp_nxt     = older ? stamp_r : best_stamp_in;
    bidx_nxt       = older ? IDX : best_idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ctl_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      ctl_r <= ctl_nxt;
    end
    size_r   <= size_nxt;
    hdl_r    <= hdl_nxt;
    stamp_r  <= stamp_nxt;
    osize_r  <= size_in;
    ohdl_r   <= hdl_in;
    ostamp_r <= stamp_in;
    res_r    <= res_nxt;
    bstamp_r <= bstamp_nxt;
    bidx_r   <= bidx_nxt;
  end

  assign ctl_out        = ctl_r;
  assign size_out       = osize_r;
  assign hdl_out        = ohdl_r;
  assign stamp_out      = ostamp_r;
  assign res_out        = res_r;
  assign best_stamp_out = bstamp_r;
  assign best_idx_out   = bidx_r;

endmodule

// ----- rtl/buffer_recycle_cache.sv -----
// Channel | Dir | Handshake   | Payload
// in_ch   | in  | valid/ready | mode, size_bytes, handle
// out_ch  | out | valid/ready | hit, out_handle, evict_valid, evict_handle
//
// One transaction at a time walks the row of ENTRIES cells, one cell a cycle;
// its result is presented after the chain walk and the capture of the chain end,
// with the victim write and the result load on one edge.
// Synchronous active-low reset empties every entry and clears the counter.
// A stalled result holds in the output register; the next transaction is
// accepted once that result has been loaded, even while it waits.
module buffer_recycle_cache #(
  parameter int unsigned ENTRIES = brc_pkg::ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  brc_in_if.sink    in_ch,
  brc_out_if.source out_ch
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t                        state_r, state_nxt;
  logic [brc_pkg::STAMP_W-1:0]   cnt_r, cnt_nxt;

  // Chain entry stage
  brc_pkg::brc_ctl_t             req_ctl_r, req_ctl_nxt;
  logic [brc_pkg::SIZE_W-1:0]    req_size_r, req_size_nxt;
  logic [brc_pkg::HDL_W-1:0]     req_hdl_r, req_hdl_nxt;
  logic [brc_pkg::STAMP_W-1:0]   req_stamp_r, req_stamp_nxt;

  // Captured chain end
  brc_pkg::brc_ctl_t             fin_ctl_r, fin_ctl_nxt;
  logic [brc_pkg::SIZE_W-1:0]    fin_size_r, fin_size_nxt;
  logic [brc_pkg::HDL_W-1:0]     fin_hdl_r, fin_hdl_nxt;
  logic [brc_pkg::STAMP_W-1:0]   fin_stamp_r, fin_stamp_nxt;
  logic [brc_pkg::HDL_W-1:0]     fin_res_r, fin_res_nxt;
  logic [IDX_W-1:0]              fin_idx_r, fin_idx_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [brc_pkg::HDL_W-1:0]     out_hdl_r, out_hdl_nxt;
  logic                          out_ev_r, out_ev_nxt;
  logic [brc_pkg::HDL_W-1:0]     out_evh_r, out_evh_nxt;

  // Chain links
  brc_pkg::brc_ctl_t             c_ctl   [ENTRIES+1];
  logic [brc_pkg::SIZE_W-1:0]    c_size  [ENTRIES+1];
  logic [brc_pkg::HDL_W-1:0]     c_hdl   [ENTRIES+1];
  logic [brc_pkg::STAMP_W-1:0]   c_stamp [ENTRIES+1];
  logic [brc_pkg::HDL_W-1:0]     c_res   [ENTRIES+1];
  logic [brc_pkg::STAMP_W-1:0]   c_bst   [ENTRIES+1];
  logic [IDX_W-1:0]              c_bidx  [ENTRIES+1];

  logic accept, fin_evict, load, wr_en;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Head of the chain
  assign c_ctl[0]   = req_ctl_r;
  assign c_size[0]  = req_size_r;
  assign c_hdl[0]   = req_hdl_r;
  assign c_stamp[0] = req_stamp_r;
  assign c_res[0]   = '0;
  assign c_bst[0]   = brc_pkg::STAMP_MAX;
  assign c_bidx[0]  = '0;

  // Row of entry cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    brc_cell #(
      .IDX_W (IDX_W),
      .IDX   (IDX_W'(g))
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl_in         (c_ctl[g]),
      .size_in        (c_size[g]),
      .hdl_in         (c_hdl[g]),
      .stamp_in       (c_stamp[g]),
      .res_in         (c_res[g]),
      .best_stamp_in  (c_bst[g]),
      .best_idx_in    (c_bidx[g]),
      .wr_en          (wr_en),
      .wr_idx         (fin_idx_r),
      .wr_size        (fin_size_r),
      .wr_hdl         (fin_hdl_r),
      .wr_stamp       (fin_stamp_r),
      .ctl_out        (c_ctl[g+1]),
      .size_out       (c_size[g+1]),
      .hdl_out        (c_hdl[g+1]),
      .stamp_out      (c_stamp[g+1]),
      .res_out        (c_res[g+1]),
      .best_stamp_out (c_bst[g+1]),
      .best_idx_out   (c_bidx[g+1])
    );
  end

  // A release still unserved at the chain end replaces the oldest entry
  assign fin_evict = (fin_ctl_r.mode == brc_pkg::MODE_RELEASE) && !fin_ctl_r.done;
  assign load      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign wr_en     = load && fin_evict;

  // Sequencer and registered outputs
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    req_ctl_nxt   = '0;
    req_size_nxt  = req_size_r;
    req_hdl_nxt   = req_hdl_r;
    req_stamp_nxt = req_stamp_r;
    fin_ctl_nxt   = fin_ctl_r;
    fin_size_nxt  = fin_size_r;
    fin_hdl_nxt   = fin_hdl_r;
    fin_stamp_nxt = fin_stamp_r;
    fin_res_nxt   = fin_res_r;
    fin_idx_nxt   = fin_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_hdl_nxt   = out_hdl_r;
    out_ev_nxt    = out_ev_r;
    out_evh_nxt   = out_evh_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_ctl_nxt.valid = 1'b1;
          req_ctl_nxt.mode  = in_ch.mode;
          // null release is served on entry
          req_ctl_nxt.done  = (in_ch.mode == brc_pkg::MODE_RELEASE) && (in_ch.handle == '0);
          req_size_nxt      = in_ch.size_bytes;
          req_hdl_nxt       = in_ch.handle;
          req_stamp_nxt     = cnt_r;
          if ((in_ch.mode == brc_pkg::MODE_RELEASE) && (in_ch.handle != '0)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (c_ctl[ENTRIES].valid) begin
          fin_ctl_nxt   = c_ctl[ENTRIES];
          fin_size_nxt  = c_size[ENTRIES];
          fin_hdl_nxt   = c_hdl[ENTRIES];
          fin_stamp_nxt = c_stamp[ENTRIES];
          fin_res_nxt   = c_res[ENTRIES];
          fin_idx_nxt   = c_bidx[ENTRIES];
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = fin_ctl_r.hit;
          out_hdl_nxt   = fin_ctl_r.hit ? fin_res_r : '0;
          out_ev_nxt    = fin_evict;
          out_evh_nxt   = fin_evict ? fin_res_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      req_ctl_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      req_ctl_r   <= req_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_size_r  <= req_size_nxt;
    req_hdl_r   <= req_hdl_nxt;
    req_stamp_r <= req_stamp_nxt;
    fin_ctl_r   <= fin_ctl_nxt;
    fin_size_r  <= fin_size_nxt;
    fin_hdl_r   <= fin_hdl_nxt;
    fin_stamp_r <= fin_stamp_nxt;
    fin_res_r   <= fin_res_nxt;
    fin_idx_r   <= fin_idx_nxt;
    out_hit_r   <= out_hit_nxt;
    out_hdl_r   <= out_hdl_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evh_r   <= out_evh_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.out_handle   = out_hdl_r;
  assign out_ch.evict_valid  = out_ev_r;
  assign out_ch.evict_handle = out_evh_r;

endmodule
